FILE: hdl/gavr_pkg.sv
package gavr_pkg;

	localparam int NUM_PENS = 16;
	localparam int PIX_PER_BYTE = 8;

	// Request kinds.
	localparam logic [1:0] KIND_CRTC  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;

	// Gate array write functions, taken from write_data[7:6].
	localparam logic [1:0] FN_PEN    = 2'd0;
	localparam logic [1:0] FN_COLOUR = 2'd1;
	localparam logic [1:0] FN_MODE   = 2'd2;

	// Level kinds on the result.
	localparam logic [1:0] LEVEL_SYNC   = 2'd0;
	localparam logic [1:0] LEVEL_BORDER = 2'd1;
	localparam logic [1:0] LEVEL_PIXELS = 2'd2;

	// Video modes.
	localparam logic [1:0] VMODE_0 = 2'd0;
	localparam logic [1:0] VMODE_1 = 2'd1;
	localparam logic [1:0] VMODE_2 = 2'd2;

	localparam logic [5:0] LINES_PER_IRQ = 6'd52;
	localparam logic [1:0] VSYNC_DELAY = 2'd2;
	localparam logic [1:0] RESET_VMODE = VMODE_2;

	typedef logic [5:0] colour_t;
	typedef colour_t [NUM_PENS-1:0] palette_t;

	// Hardware colour map: 2-bit R, G, B packed as {R, G, B}.
	localparam colour_t HW_COLOURS [32] = '{
		6'h15, 6'h15, 6'h09, 6'h29, 6'h01, 6'h21, 6'h05, 6'h25,
		6'h21, 6'h29, 6'h28, 6'h2a, 6'h20, 6'h22, 6'h24, 6'h26,
		6'h01, 6'h09, 6'h08, 6'h0a, 6'h00, 6'h02, 6'h04, 6'h06,
		6'h11, 6'h19, 6'h18, 6'h1a, 6'h10, 6'h12, 6'h14, 6'h16
	};

	typedef struct packed {
		logic [1:0]  mode;
		logic        hsync;
		logic        vsync;
		logic        disp_en;
		logic [13:0] ma_addr;
		logic [4:0]  raster_row;
		logic [7:0]  ram_byte_even;
		logic [7:0]  ram_byte_odd;
		logic [7:0]  write_data;
	} gavr_in_t;

	typedef struct packed {
		logic [15:0] video_address;
		logic [1:0]  level_kind;
		logic [47:0] pixels_first;
		logic [47:0] pixels_second;
		logic [3:0]  pixels_per_byte;
		logic [5:0]  border_colour;
		logic        interrupt_request;
		logic [1:0]  video_mode;
	} gavr_out_t;

	// Control state seen by the datapath for one request.
	typedef struct packed {
		logic [1:0] decode_mode;
		logic [1:0] mode_next;
		colour_t    border_next;
		logic       irq_next;
	} gavr_status_t;

	function automatic logic [3:0] pixels_for_mode(input logic [1:0] m);
		logic [3:0] n;
		n = 4'd2;
		if (m == VMODE_1) n = 4'd4;
		else if (m == VMODE_2) n = 4'd8;
		return n;
	endfunction

endpackage

FILE: hdl/gavr_lane.sv
module gavr_lane import gavr_pkg::*; (
	input  logic [1:0] mode,
	input  logic [7:0] data,
	input  logic [2:0] pos,
	input  palette_t   palette,
	output colour_t    colour
);

	logic [2:0] s;
	logic [3:0] pen;
	logic       active;

	always_comb begin
		s = 3'd7;
		pen = '0;
		unique case (mode)
			VMODE_0: begin
				s = 3'd7 - {2'b00, pos[0]};
				pen = {data[s - 3'd6], data[s - 3'd2], data[s - 3'd4], data[s]};
			end
			VMODE_2: begin
				s = 3'd7 - pos;
				pen = {3'b000, data[s]};
			end
			default: begin
				// Modes 1 and 3 share the bit-pair layout.
				s = 3'd7 - {1'b0, pos[1:0]};
				pen = {2'b00, data[s - 3'd4], data[s]};
			end
		endcase
		active = {1'b0, pos} < pixels_for_mode(mode);
	end

	assign colour = active ? palette[pen] : '0;

endmodule

FILE: hdl/gavr_ctrl.sv
module gavr_ctrl import gavr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  gavr_in_t     req,
	output gavr_status_t status,
	output palette_t     palette
);

	logic [5:0] line_counter_q, line_counter_n;
	logic [1:0] vsync_delay_q, vsync_delay_n;
	logic       irq_q, irq_n;
	logic       prev_hsync_q, prev_hsync_n;
	logic       prev_vsync_q, prev_vsync_n;
	logic [1:0] active_mode_q, active_mode_n;
	logic [1:0] pending_mode_q, pending_mode_n;
	logic [4:0] pen_q, pen_n;
	colour_t    border_q, border_n;
	palette_t   palette_q;
	logic       pal_we;
	colour_t    map_colour;

	assign map_colour = HW_COLOURS[req.write_data[4:0]];

	always_comb begin
		line_counter_n = line_counter_q;
		vsync_delay_n = vsync_delay_q;
		irq_n = irq_q;
		prev_hsync_n = prev_hsync_q;
		prev_vsync_n = prev_vsync_q;
		active_mode_n = active_mode_q;
		pending_mode_n = pending_mode_q;
		pen_n = pen_q;
		border_n = border_q;
		pal_we = 1'b0;
		unique case (req.mode)
			KIND_CRTC: begin
				// Trailing edge of hsync: new mode and one raster line on the timer.
				if (prev_hsync_q && !req.hsync) begin
					active_mode_n = pending_mode_q;
					line_counter_n = line_counter_q + 6'd1;
					if (line_counter_n == LINES_PER_IRQ) begin
						line_counter_n = '0;
						irq_n = 1'b1;
					end
					if (vsync_delay_q != '0) begin
						vsync_delay_n = vsync_delay_q - 2'd1;
						if (vsync_delay_n == '0) begin
							if (line_counter_n[5]) irq_n = 1'b1;
							line_counter_n = '0;
						end
					end
				end
				if (!prev_vsync_q && req.vsync) vsync_delay_n = VSYNC_DELAY;
				prev_hsync_n = req.hsync;
				prev_vsync_n = req.vsync;
			end
			KIND_WRITE: begin
				case (req.write_data[7:6])
					FN_PEN: pen_n = req.write_data[4:0];
					FN_COLOUR: begin
						if (pen_q[4]) border_n = map_colour;
						else pal_we = 1'b1;
					end
					FN_MODE: begin
						if (req.write_data[4]) begin
							line_counter_n = '0;
							irq_n = 1'b0;
						end
						pending_mode_n = req.write_data[1:0];
					end
					default: ;
				endcase
			end
			KIND_ACK: begin
				irq_n = 1'b0;
				line_counter_n[5] = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_counter_q <= '0;
			vsync_delay_q <= '0;
			irq_q <= 1'b0;
			prev_hsync_q <= 1'b0;
			prev_vsync_q <= 1'b0;
			active_mode_q <= RESET_VMODE;
			pending_mode_q <= RESET_VMODE;
			pen_q <= '0;
			border_q <= '0;
			palette_q <= '0;
		end else if (fire) begin
			line_counter_q <= line_counter_n;
			vsync_delay_q <= vsync_delay_n;
			irq_q <= irq_n;
			prev_hsync_q <= prev_hsync_n;
			prev_vsync_q <= prev_vsync_n;
			active_mode_q <= active_mode_n;
			pending_mode_q <= pending_mode_n;
			pen_q <= pen_n;
			border_q <= border_n;
			if (pal_we) palette_q[pen_q[3:0]] <= map_colour;
		end
	end

	assign status.decode_mode = active_mode_q;
	assign status.mode_next = active_mode_n;
	assign status.border_next = border_n;
	assign status.irq_next = irq_n;
	assign palette = palette_q;

	// The counter wraps at 52 lines, so it never reaches that value.
	assert property (@(posedge clk) disable iff (!arst_n) line_counter_q < LINES_PER_IRQ)
		else $error("line counter out of range");

	// The vsync delay is only ever loaded with two and counts down.
	assert property (@(posedge clk) disable iff (!arst_n) vsync_delay_q != 2'd3)
		else $error("vsync delay out of range");

endmodule

FILE: hdl/gate_array_video_and_raster_interrupt_top.sv
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req (gavr_in_t)
// result    out        rsp_valid/rsp_stall  rsp (gavr_out_t)
//
// One request is taken every cycle unless req_stall is high; its result is registered.
// Sixteen pixel lanes, eight per RAM byte, look up the palette in the accept cycle.
// Reset clears the palette, timer and pens and sets mode 2 active and posted.
// A two-entry output buffer absorbs one stalled result; req_stall rises only when both
// entries are full.
module gate_array_video_and_raster_interrupt_top import gavr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  gavr_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output gavr_out_t rsp
);

	gavr_status_t         status;
	palette_t             palette;
	logic [7:0][5:0]      first_px, second_px;
	gavr_out_t            res;
	gavr_out_t            out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 req_fire, rsp_fire, is_crtc, is_pix;

	assign req_fire = req_valid && !req_stall;
	assign rsp_fire = out_valid_q && !rsp_stall;

	gavr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (req_fire),
		.req     (req),
		.status  (status),
		.palette (palette)
	);

	for (genvar i = 0; i < PIX_PER_BYTE; i++) begin : g_lane
		gavr_lane u_even (
			.mode    (status.decode_mode),
			.data    (req.ram_byte_even),
			.pos     (3'(i)),
			.palette (palette),
			.colour  (first_px[i])
		);
		gavr_lane u_odd (
			.mode    (status.decode_mode),
			.data    (req.ram_byte_odd),
			.pos     (3'(i)),
			.palette (palette),
			.colour  (second_px[i])
		);
	end

	// Merge the lanes into one result.
	always_comb begin
		is_crtc = req.mode == KIND_CRTC;
		res.video_address = '0;
		res.level_kind = LEVEL_SYNC;
		if (is_crtc) begin
			res.video_address = {req.ma_addr[13:12], req.raster_row[2:0],
				req.ma_addr[9:0], 1'b0};
			if (req.hsync || req.vsync) res.level_kind = LEVEL_SYNC;
			else if (!req.disp_en) res.level_kind = LEVEL_BORDER;
			else res.level_kind = LEVEL_PIXELS;
		end
		is_pix = is_crtc && res.level_kind == LEVEL_PIXELS;
		res.pixels_first = is_pix ? first_px : '0;
		res.pixels_second = is_pix ? second_px : '0;
		res.pixels_per_byte = pixels_for_mode(status.decode_mode);
		res.border_colour = status.border_next;
		res.interrupt_request = status.irq_next;
		res.video_mode = status.mode_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (rsp_fire) skid_valid_q <= 1'b0;
		end else if (req_fire) begin
			if (out_valid_q && rsp_stall) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_fire) out_q <= skid_q;
		end else if (req_fire) begin
			if (out_valid_q && rsp_stall) skid_q <= res;
			else out_q <= res;
		end
	end

	assign req_stall = skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	// The skid entry only fills behind a held output entry.
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output entry");

	// Sync and border cycles carry no pixel colours.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.level_kind != LEVEL_PIXELS |->
			rsp.pixels_first == '0 && rsp.pixels_second == '0)
		else $error("pixel colours outside active picture");

	// A full buffer that is not drained keeps refusing requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && rsp_stall |=> req_stall)
		else $error("request taken while buffer full");

endmodule

FILE: tb/gavr_checker.sv
module gavr_checker import gavr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  gavr_in_t  req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  gavr_out_t rsp,
	output int        fail_count,
	output int        awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// Hardware colour number to {R, G, B}, two bits each.
	localparam colour_t COLOUR_MAP [32] = '{
		6'h15, 6'h15, 6'h09, 6'h29, 6'h01, 6'h21, 6'h05, 6'h25,
		6'h21, 6'h29, 6'h28, 6'h2a, 6'h20, 6'h22, 6'h24, 6'h26,
		6'h01, 6'h09, 6'h08, 6'h0a, 6'h00, 6'h02, 6'h04, 6'h06,
		6'h11, 6'h19, 6'h18, 6'h1a, 6'h10, 6'h12, 6'h14, 6'h16
	};

	logic [5:0] line_cnt;
	logic [1:0] vs_delay;
	logic       irq;
	logic       last_hs;
	logic       last_vs;
	logic [1:0] live_mode;
	logic [1:0] posted_mode;
	logic [4:0] pen_sel;
	colour_t    palette [NUM_PENS];
	colour_t    border;

	gavr_out_t  expected_q [$];

	function automatic logic [3:0] lanes_for(input logic [1:0] m);
		if (m == VMODE_1) return 4'd4;
		if (m == VMODE_2) return 4'd8;
		return 4'd2;
	endfunction

	function automatic logic [3:0] pen_at(input logic [1:0] m, input logic [7:0] c,
			input int p);
		int s;
		logic [3:0] idx;
		case (m)
			VMODE_0: begin
				s = 7 - (p % 2);
				idx = {c[s-6], c[s-2], c[s-4], c[s]};
			end
			VMODE_2: idx = {3'b000, c[7-p]};
			default: begin
				// Mode 3 lands here too and uses the two-bit pairs of the first two pixels.
				s = 7 - (p % 4);
				idx = {2'b00, c[s-4], c[s]};
			end
		endcase
		return idx;
	endfunction

	function automatic logic [47:0] colours_of(input logic [1:0] m, input logic [7:0] c);
		logic [47:0] acc;
		acc = '0;
		for (int p = 0; p < lanes_for(m); p++)
			acc[6*p +: 6] = palette[pen_at(m, c, p)];
		return acc;
	endfunction

	task automatic count_line();
		line_cnt = line_cnt + 6'd1;
		if (line_cnt == LINES_PER_IRQ) begin
			line_cnt = '0;
			irq = 1'b1;
		end
		if (vs_delay != 2'd0) begin
			vs_delay = vs_delay - 2'd1;
			if (vs_delay == 2'd0) begin
				if (line_cnt[5])
					irq = 1'b1;
				line_cnt = '0;
			end
		end
	endtask

	task automatic predict_result(input gavr_in_t r);
		gavr_out_t e;
		logic [1:0] dec_mode;
		dec_mode = live_mode;
		e = '0;
		case (r.mode)
			KIND_CRTC: begin
				e.video_address = {r.ma_addr[13:12], r.raster_row[2:0],
					r.ma_addr[9:0], 1'b0};
				if (r.hsync || r.vsync) begin
					e.level_kind = LEVEL_SYNC;
				end else if (!r.disp_en) begin
					e.level_kind = LEVEL_BORDER;
				end else begin
					e.level_kind = LEVEL_PIXELS;
					e.pixels_first = colours_of(dec_mode, r.ram_byte_even);
					e.pixels_second = colours_of(dec_mode, r.ram_byte_odd);
				end
				if (last_hs && !r.hsync) begin
					live_mode = posted_mode;
					count_line();
				end
				if (!last_vs && r.vsync)
					vs_delay = VSYNC_DELAY;
				last_hs = r.hsync;
				last_vs = r.vsync;
			end
			KIND_WRITE: begin
				case (r.write_data[7:6])
					FN_PEN: pen_sel = r.write_data[4:0];
					FN_COLOUR: begin
						if (pen_sel[4])
							border = COLOUR_MAP[r.write_data[4:0]];
						else
							palette[pen_sel[3:0]] = COLOUR_MAP[r.write_data[4:0]];
					end
					FN_MODE: begin
						if (r.write_data[4]) begin
							line_cnt = '0;
							irq = 1'b0;
						end
						posted_mode = r.write_data[1:0];
					end
					default: ;
				endcase
			end
			KIND_ACK: begin
				irq = 1'b0;
				line_cnt[5] = 1'b0;
			end
			default: ;
		endcase
		e.pixels_per_byte = lanes_for(dec_mode);
		e.border_colour = border;
		e.interrupt_request = irq;
		e.video_mode = live_mode;
		expected_q.push_back(e);
	endtask

	task automatic check_result(input gavr_out_t a);
		gavr_out_t e;
		if (expected_q.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: result with no request waiting: %h", $realtime, a);
			fail_count++;
			return;
		end
		e = expected_q.pop_front();
		if (a.video_address !== e.video_address || a.level_kind !== e.level_kind ||
				a.pixels_first !== e.pixels_first || a.pixels_second !== e.pixels_second ||
				a.pixels_per_byte !== e.pixels_per_byte ||
				a.border_colour !== e.border_colour ||
				a.interrupt_request !== e.interrupt_request ||
				a.video_mode !== e.video_mode) begin
			if (fail_count < 10) begin
				$display("%0t: exp addr %h lvl %0d px %h %h n %0d bdr %h irq %b vm %0d",
					$realtime, e.video_address, e.level_kind, e.pixels_first,
					e.pixels_second, e.pixels_per_byte, e.border_colour,
					e.interrupt_request, e.video_mode);
				$display("%0t: got addr %h lvl %0d px %h %h n %0d bdr %h irq %b vm %0d",
					$realtime, a.video_address, a.level_kind, a.pixels_first,
					a.pixels_second, a.pixels_per_byte, a.border_colour,
					a.interrupt_request, a.video_mode);
			end
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt = '0;
			vs_delay = '0;
			irq = 1'b0;
			last_hs = 1'b0;
			last_vs = 1'b0;
			live_mode = RESET_VMODE;
			posted_mode = RESET_VMODE;
			pen_sel = '0;
			for (int i = 0; i < NUM_PENS; i++)
				palette[i] = '0;
			border = '0;
			expected_q.delete();
			fail_count = 0;
			awaiting <= 0;
		end else begin
			// A result never belongs to the request taken on the same edge.
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (req_valid && !req_stall)
				predict_result(req);
			awaiting <= expected_q.size();
		end
	end

endmodule

FILE: tb/tb_gate_array_video_and_raster_interrupt_top.sv
module tb_gate_array_video_and_raster_interrupt_top;
	import gavr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam logic [1:0] VMODE_3 = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	gavr_in_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	gavr_out_t rsp;

	int fail_count;
	int awaiting;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic pressure_on = 1'b0;

	int n_char = 0;
	int n_write = 0;
	int n_ack = 0;
	int n_spare = 0;

	// Raster position for the well-formed part of the stimulus.
	int col = 0;
	int line_len = 4;
	int hs_len = 1;
	int vs_left = 0;
	int frame_gap = 30;

	gate_array_video_and_raster_interrupt_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	gavr_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, awaiting);
			$display("gate_array_video_and_raster_interrupt_top: mismatch");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		int hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic gavr_in_t char_cycle(input logic hs, input logic vs, input logic de,
			input logic [13:0] ma, input logic [4:0] ra, input logic [7:0] b0,
			input logic [7:0] b1);
		gavr_in_t r;
		r = '0;
		r.mode = KIND_CRTC;
		r.hsync = hs;
		r.vsync = vs;
		r.disp_en = de;
		r.ma_addr = ma;
		r.raster_row = ra;
		r.ram_byte_even = b0;
		r.ram_byte_odd = b1;
		return r;
	endfunction

	function automatic gavr_in_t ga_write(input logic [7:0] data);
		gavr_in_t r;
		r = '0;
		r.mode = KIND_WRITE;
		r.write_data = data;
		return r;
	endfunction

	function automatic gavr_in_t ack_req();
		gavr_in_t r;
		r = '0;
		r.mode = KIND_ACK;
		return r;
	endfunction

	task automatic offer(input gavr_in_t item);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		case (item.mode)
			KIND_CRTC: n_char++;
			KIND_WRITE: n_write++;
			KIND_ACK: n_ack++;
			KIND_SPARE: n_spare++;
		endcase
	endtask

	task automatic next_char(output gavr_in_t item);
		logic hs;
		hs = (col >= line_len);
		item = char_cycle(hs, vs_left > 0, $urandom_range(9) != 0, 14'($urandom),
			5'($urandom), 8'($urandom), 8'($urandom));
		col++;
		if (col == line_len + hs_len) begin
			col = 0;
			line_len = $urandom_range(2, 8);
			hs_len = $urandom_range(1, 2);
			if (vs_left > 0) begin
				vs_left--;
			end else begin
				frame_gap--;
				if (frame_gap == 0) begin
					vs_left = $urandom_range(2, 5);
					frame_gap = $urandom_range(20, 80);
				end
			end
		end
	endtask

	// Mostly a raster with writes and acknowledges mixed in; a few fully random requests.
	task automatic raster_run(input int count);
		gavr_in_t item;
		logic [63:0] bits;
		logic [7:0] data;
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 7) begin
				bits = {$urandom, $urandom};
				item = bits[$bits(gavr_in_t)-1:0];
			end else if (pick < 17) begin
				data = 8'($urandom_range(255));
				if (data[7:6] == FN_MODE)
					data[4] = ($urandom_range(15) == 0);
				item = ga_write(data);
			end else if (pick < 20) begin
				item = ack_req();
			end else begin
				next_char(item);
			end
			offer(item);
		end
	endtask

	task automatic directed_run();
		gavr_in_t spare;
		spare = '1;
		offer(ga_write({FN_PEN, 1'b0, 5'd0}));
		offer(ga_write({FN_COLOUR, 1'b0, 5'd11}));
		offer(ga_write({FN_PEN, 1'b0, 5'd15}));
		offer(ga_write({FN_COLOUR, 1'b1, 5'd31}));
		offer(ga_write({FN_PEN, 1'b1, 5'd31}));
		offer(ga_write({FN_COLOUR, 1'b0, 5'd16}));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h3fff, 5'h1f, 8'hff, 8'h00));
		offer(char_cycle(1'b0, 1'b0, 1'b0, 14'h2aaa, 5'h15, 8'h55, 8'haa));
		// Post mode 0 and clear the interrupt timer, then let a line end take it in.
		offer(ga_write({FN_MODE, 1'b0, 1'b1, 2'b00, VMODE_0}));
		offer(char_cycle(1'b1, 1'b0, 1'b1, 14'h1555, 5'h0a, 8'h0f, 8'hf0));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h0001, 5'h07, 8'ha5, 8'h3c));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h0400, 5'h10, 8'h5a, 8'hf0));
		offer(ga_write({FN_MODE, 1'b0, 1'b0, 2'b00, VMODE_1}));
		offer(char_cycle(1'b1, 1'b0, 1'b0, 14'h3000, 5'h08, 8'h00, 8'h00));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h03ff, 5'h03, 8'hc3, 8'h81));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h0800, 5'h04, 8'h99, 8'h66));
		offer(ga_write({FN_MODE, 1'b0, 1'b0, 2'b00, VMODE_3}));
		offer(char_cycle(1'b1, 1'b0, 1'b1, 14'h0000, 5'h00, 8'hff, 8'hff));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h2000, 5'h02, 8'hcc, 8'h33));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h1000, 5'h01, 8'h88, 8'h44));
		offer(ga_write({FN_NONE, 6'h3f}));
		offer(spare);
		offer(ack_req());
		offer(char_cycle(1'b0, 1'b1, 1'b1, 14'h0155, 5'h06, 8'h12, 8'h34));
		offer(char_cycle(1'b0, 1'b0, 1'b1, 14'h0000, 5'h00, 8'h00, 8'h00));
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 20;
		stall_pct = 47;
		directed_run();
		raster_run(640);

		idle_pct = 47;
		stall_pct = 20;
		raster_run(640);

		// With no idling the sender keeps offering while results are held back.
		idle_pct = 0;
		stall_pct = 0;
		pressure_on = 1'b1;
		raster_run(645);

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("requests: %0d character cycles, %0d gate array writes, %0d acknowledges,",
			n_char, n_write, n_ack);
		$display("%0d spare; three idle and stall mixes, one long result hold-off, %0d mismatches",
			n_spare, fail_count);
		if (fail_count == 0)
			$display("gate_array_video_and_raster_interrupt_top: match");
		else
			$display("gate_array_video_and_raster_interrupt_top: mismatch");
		$finish;
	end

endmodule

FILE: files.f
hdl/gavr_pkg.sv
hdl/gavr_lane.sv
hdl/gavr_ctrl.sv
hdl/gate_array_video_and_raster_interrupt_top.sv
tb/gavr_checker.sv
tb/tb_gate_array_video_and_raster_interrupt_top.sv
